// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and GF(2^8) helpers for the AES pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned NumRounds = 10;

	typedef logic [7:0]   byte_t;
	typedef logic [127:0] block_t;
	typedef logic [3:0]   round_idx_t;

	typedef enum logic [0:0] {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} cmd_t;

	// Configuration register indexes.
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5, 8'h30, 8'h01, 8'h67, 8'h2b,
		8'hfe, 8'hd7, 8'hab, 8'h76, 8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0, 8'hb7, 8'hfd, 8'h93, 8'h26,
		8'h36, 8'h3f, 8'hf7, 8'hcc, 8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a, 8'h07, 8'h12, 8'h80, 8'he2,
		8'heb, 8'h27, 8'hb2, 8'h75, 8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84, 8'h53, 8'hd1, 8'h00, 8'hed,
		8'h20, 8'hfc, 8'hb1, 8'h5b, 8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85, 8'h45, 8'hf9, 8'h02, 8'h7f,
		8'h50, 8'h3c, 8'h9f, 8'ha8, 8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2, 8'hcd, 8'h0c, 8'h13, 8'hec,
		8'h5f, 8'h97, 8'h44, 8'h17, 8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88, 8'h46, 8'hee, 8'hb8, 8'h14,
		8'hde, 8'h5e, 8'h0b, 8'hdb, 8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79, 8'he7, 8'hc8, 8'h37, 8'h6d,
		8'h8d, 8'hd5, 8'h4e, 8'ha9, 8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6, 8'he8, 8'hdd, 8'h74, 8'h1f,
		8'h4b, 8'hbd, 8'h8b, 8'h8a, 8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e, 8'he1, 8'hf8, 8'h98, 8'h11,
		8'h69, 8'hd9, 8'h8e, 8'h94, 8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68, 8'h41, 8'h99, 8'h2d, 8'h0f,
		8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] INV_BOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38, 8'hbf, 8'h40, 8'ha3, 8'h9e,
		8'h81, 8'hf3, 8'hd7, 8'hfb, 8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb, 8'h54, 8'h7b, 8'h94, 8'h32,
		8'ha6, 8'hc2, 8'h23, 8'h3d, 8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2, 8'h76, 8'h5b, 8'ha2, 8'h49,
		8'h6d, 8'h8b, 8'hd1, 8'h25, 8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92, 8'h6c, 8'h70, 8'h48, 8'h50,
		8'hfd, 8'hed, 8'hb9, 8'hda, 8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a, 8'hf7, 8'he4, 8'h58, 8'h05,
		8'hb8, 8'hb3, 8'h45, 8'h06, 8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b, 8'h3a, 8'h91, 8'h11, 8'h41,
		8'h4f, 8'h67, 8'hdc, 8'hea, 8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85, 8'he2, 8'hf9, 8'h37, 8'he8,
		8'h1c, 8'h75, 8'hdf, 8'h6e, 8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b, 8'hfc, 8'h56, 8'h3e, 8'h4b,
		8'hc6, 8'hd2, 8'h79, 8'h20, 8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31, 8'hb1, 8'h12, 8'h10, 8'h59,
		8'h27, 8'h80, 8'hec, 8'h5f, 8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef, 8'ha0, 8'he0, 8'h3b, 8'h4d,
		8'hae, 8'h2a, 8'hf5, 8'hb0, 8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26, 8'he1, 8'h69, 8'h14, 8'h63,
		8'h55, 8'h21, 8'h0c, 8'h7d
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// Byte n of a block sits at bits [127-8n -: 8].
	function automatic byte_t get_byte(block_t b, int unsigned n);
		return b[127 - 8 * n -: 8];
	endfunction

	function automatic byte_t xtime(byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// One forward key expansion step: round key i-1 to round key i.
	function automatic block_t key_step(block_t k, byte_t rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {FWD_BOX[w3[23:16]] ^ rc, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// Forward round without AddRoundKey; the last round skips MixColumns.
	function automatic block_t enc_round(block_t s, logic last);
		block_t t, m;
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (c * 4 + r) -: 8] = FWD_BOX[get_byte(s, ((c + r) % 4) * 4 + r)];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(t, c * 4);
			a1 = get_byte(t, c * 4 + 1);
			a2 = get_byte(t, c * 4 + 2);
			a3 = get_byte(t, c * 4 + 3);
			m[127 - 8 * (c * 4) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			m[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			m[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			m[127 - 8 * (c * 4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return last ? t : m;
	endfunction

	function automatic block_t inv_mix(block_t s);
		block_t m;
		byte_t a0, a1, a2, a3, u, v;
		for (int c = 0; c < 4; c++) begin
			// Pre-multiply by {05,00,04,00} to reduce InvMixColumns to MixColumns.
			a0 = get_byte(s, c * 4);
			a1 = get_byte(s, c * 4 + 1);
			a2 = get_byte(s, c * 4 + 2);
			a3 = get_byte(s, c * 4 + 3);
			u = xtime(xtime(a0 ^ a2));
			v = xtime(xtime(a1 ^ a3));
			a0 = a0 ^ u;
			a1 = a1 ^ v;
			a2 = a2 ^ u;
			a3 = a3 ^ v;
			m[127 - 8 * (c * 4) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			m[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			m[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			m[127 - 8 * (c * 4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return m;
	endfunction

	// Inverse round: InvShiftRows and InvSubBytes, then AddRoundKey, then
	// InvMixColumns unless this is the final round.
	function automatic block_t dec_round(block_t s, block_t rk, logic last);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (c * 4 + r) -: 8] = INV_BOX[get_byte(s, ((c + 4 - r) % 4) * 4 + r)];
			end
		end
		t = t ^ rk;
		return last ? t : inv_mix(t);
	endfunction

endpackage

// ===== hw/rtl/aes128_ecb_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 ECB block cipher
// Eleven-register pipeline: a key whitening stage, then one round per stage.
//
//   channel   direction  handshake          payload
//   input     in         valid / stall      command, block_high, block_low
//   output    out        out_valid / out_stall  result_high, result_low
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One block per cycle while the input is not stalled; a result passes through
// the whitening register and then the ten round registers behind it.
// Reset clears the valid bits and loads the zero key. A stalled output holds
// each full stage that has no empty stage after it; an empty stage still fills under stall.
// After a key write the input stalls while the decrypt key settles.
// ----------------------------------------------------------------------------
module aes128_ecb_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic        command,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	import aes_pkg::*;

	localparam int unsigned Depth = NumRounds + 1;

	block_t key_q, last_key_q;
	logic   key_busy;
	logic   vld [Depth];
	cmd_t   cmd [Depth];
	block_t st  [Depth];
	block_t rk  [Depth];
	logic   adv [Depth];

	aes_key_prep u_key (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .key_q(key_q), .last_key_q(last_key_q),
		.busy(key_busy)
	);

	// A stage advances when its successor advances or when it is itself empty.
	always_comb begin
		adv[Depth - 1] = !out_stall || !vld[Depth - 1];
		for (int i = Depth - 2; i >= 0; i--) begin
			adv[i] = adv[i + 1] || !vld[i];
		end
	end

	assign stall = !adv[0] || key_busy;

	// Whitening stage.
	block_t in_blk, wkey;
	assign in_blk = {block_high, block_low};
	assign wkey = (command == CMD_DECRYPT) ? last_key_q : key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (adv[0]) begin
			vld[0] <= valid && !key_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			cmd[0] <= cmd_t'(command);
			st[0] <= in_blk ^ wkey;
			rk[0] <= wkey;
		end
	end

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		aes_round_stage u_round (
			.clk(clk), .arst_n(arst_n), .advance(adv[g + 1]),
			.stage_idx(round_idx_t'(g)),
			.in_valid(vld[g]), .in_cmd(cmd[g]), .in_state(st[g]), .in_key(rk[g]),
			.out_valid(vld[g + 1]), .out_cmd(cmd[g + 1]), .out_state(st[g + 1]),
			.out_key(rk[g + 1])
		);
	end

	assign out_valid = vld[Depth - 1];
	assign result_high = st[Depth - 1][127:64];
	assign result_low = st[Depth - 1][63:0];

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_high))
		else $error("stalled result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		stall && !key_busy |-> vld[0] && out_stall)
		else $error("input stalled with room in pipeline");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall |=> vld[0])
		else $error("accepted block not captured");
	assert property (@(posedge clk) disable iff (!arst_n)
		key_busy |-> stall)
		else $error("input open while decrypt key settles");

endmodule

// ===== hw/rtl/aes_round_stage.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One pipeline stage: one cipher round on the state plus one key schedule step.
// ----------------------------------------------------------------------------
module aes_round_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  aes_pkg::round_idx_t stage_idx,
	input  logic            in_valid,
	input  aes_pkg::cmd_t   in_cmd,
	input  aes_pkg::block_t in_state,
	input  aes_pkg::block_t in_key,
	output logic            out_valid,
	output aes_pkg::cmd_t   out_cmd,
	output aes_pkg::block_t out_state,
	output aes_pkg::block_t out_key
);
	import aes_pkg::*;

	// Encryption carries round key i in and derives round key i+1. Decryption
	// starts from round key 10 and steps the schedule backward one round per
	// stage, so no table of all eleven round keys is carried.
	block_t enc_key, dec_key, nxt_state, nxt_key;
	logic   last;
	byte_t  rc;

	function automatic block_t key_back(block_t k, byte_t rcv);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		w3 = w3 ^ w2;
		w2 = w2 ^ w1;
		w1 = w1 ^ w0;
		t = {FWD_BOX[w3[23:16]] ^ rcv, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
		w0 = w0 ^ t;
		return {w0, w1, w2, w3};
	endfunction

	always_comb begin
		last = (stage_idx == round_idx_t'(NumRounds - 1));
		// Stage i performs encrypt round i+1, or decrypt round 9-i.
		if (in_cmd == CMD_ENCRYPT) begin
			rc = RCON[stage_idx];
		end else begin
			rc = RCON[round_idx_t'(NumRounds - 1) - stage_idx];
		end
		enc_key = key_step(in_key, rc);
		dec_key = key_back(in_key, rc);
		unique case (in_cmd)
			CMD_ENCRYPT: begin
				nxt_key = enc_key;
				nxt_state = enc_round(in_state, last) ^ enc_key;
			end
			CMD_DECRYPT: begin
				nxt_key = dec_key;
				nxt_state = dec_round(in_state, dec_key, last);
			end
			default: begin
				nxt_key = enc_key;
				nxt_state = in_state;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_cmd <= in_cmd;
			out_state <= nxt_state;
			out_key <= nxt_key;
		end
	end

endmodule

// ===== hw/rtl/aes_key_prep.sv =====
// ----------------------------------------------------------------------------
// AES key preparation
// Holds the key registers and derives the final round key for decryption,
// one schedule step per cycle after each key write.
// ----------------------------------------------------------------------------
module aes_key_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [63:0]     cfg_data,
	output aes_pkg::block_t key_q,
	output aes_pkg::block_t last_key_q,
	output logic            busy
);
	import aes_pkg::*;

	// After a write the final round key is rebuilt one schedule step a cycle
	// by a counter; busy stays high until it is done.
	// Reset loads the zero key together with its final round key.
	round_idx_t step_q;
	block_t     work_q;

	assign cfg_ready = 1'b1;
	assign busy = (step_q != round_idx_t'(NumRounds));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			step_q <= round_idx_t'(NumRounds);
		end else if (cfg_valid) begin
			if (cfg_index == REG_KEY_HIGH) begin
				key_q[127:64] <= cfg_data;
			end else begin
				key_q[63:0] <= cfg_data;
			end
			step_q <= '0;
		end else if (step_q != round_idx_t'(NumRounds)) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			last_key_q <= 128'h b4ef5bcb_3e92e211_23e951cf_6f8f188e;
		end else if (cfg_valid) begin
			work_q <= '0;
		end else if (step_q == '0) begin
			work_q <= key_step(key_q, RCON[0]);
		end else if (step_q != round_idx_t'(NumRounds)) begin
			work_q <= key_step(work_q, RCON[step_q]);
			if (step_q == round_idx_t'(NumRounds - 1)) begin
				last_key_q <= key_step(work_q, RCON[step_q]);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> step_q == '0)
		else $error("key schedule counter not restarted by write");
	assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= round_idx_t'(NumRounds))
		else $error("key schedule counter out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid && step_q == round_idx_t'(NumRounds) |=> $stable(last_key_q))
		else $error("final round key changed while settled");

endmodule

// ===== tb/tb_aes128_ecb_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 ECB block cipher testbench
// Drives the cipher with known-answer blocks and then with random blocks
// under several keys. Random idle gaps appear on the input, and the output
// stalls at random. A bit-exact cipher model predicts every result that the
// table does not give, and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_aes128_ecb_block_cipher;
	timeunit 1ns;
	timeprecision 1ps;
	import aes_pkg::*;

	localparam int unsigned IdleLimit   = 5000;
	localparam int unsigned KeySettle   = 14;
	localparam int unsigned LongHold    = 300;

	typedef struct {
		block_t key;
		cmd_t   cmd;
		block_t blk;
		bit     typed;
		block_t result;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        valid = 1'b0;
	logic        stall;
	logic        command = 1'b0;
	logic [63:0] block_high = '0;
	logic [63:0] block_low = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	block_t      pending_results[$];
	block_t      cur_key = '0;
	int unsigned error_count = 0;
	int unsigned blocks_sent = 0;
	int unsigned blocks_checked = 0;
	int unsigned decrypt_count = 0;
	int unsigned key_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b0;
	bit          stalls_on = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned hold_count = 0;

	aes128_ecb_block_cipher u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid),
		.stall      (stall),
		.command    (command),
		.block_high (block_high),
		.block_low  (block_low),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_high(result_high),
		.result_low (result_low),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	// ---------------- cipher model ----------------
	function automatic byte_t gf_product(byte_t a, byte_t b);
		byte_t acc;
		acc = '0;
		for (int n = 0; n < 8; n++) begin
			if (b[0]) acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic block_t aes_cipher(cmd_t cmd, block_t blk, block_t key);
		byte_t       sched[176];
		byte_t       s[16];
		byte_t       t[16];
		byte_t       w[4];
		byte_t       r0;
		byte_t       coef[4];
		block_t      res;
		int          rnd;
		for (int n = 0; n < 16; n++) begin
			sched[n] = key[127 - 8 * n -: 8];
			s[n] = blk[127 - 8 * n -: 8];
		end
		for (int k = 4; k < 44; k++) begin
			for (int n = 0; n < 4; n++) w[n] = sched[(k - 1) * 4 + n];
			if (k % 4 == 0) begin
				r0 = w[0];
				w[0] = FWD_BOX[w[1]] ^ RCON[k / 4 - 1];
				w[1] = FWD_BOX[w[2]];
				w[2] = FWD_BOX[w[3]];
				w[3] = FWD_BOX[r0];
			end
			for (int n = 0; n < 4; n++) sched[k * 4 + n] = sched[(k - 4) * 4 + n] ^ w[n];
		end
		if (cmd == CMD_DECRYPT) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
		rnd = (cmd == CMD_DECRYPT) ? 10 : 0;
		for (int n = 0; n < 16; n++) s[n] ^= sched[rnd * 16 + n];
		for (int i = 1; i <= 10; i++) begin
			rnd = (cmd == CMD_DECRYPT) ? 10 - i : i;
			// Row r rotates left by r when encrypting and right by r when decrypting.
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					if (cmd == CMD_DECRYPT) t[c * 4 + r] = INV_BOX[s[((c + 4 - r) % 4) * 4 + r]];
					else t[c * 4 + r] = FWD_BOX[s[((c + r) % 4) * 4 + r]];
				end
			end
			s = t;
			if (cmd == CMD_DECRYPT) for (int n = 0; n < 16; n++) s[n] ^= sched[rnd * 16 + n];
			if (i != 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) begin
						t[c * 4 + r] = '0;
						for (int k = 0; k < 4; k++)
							t[c * 4 + r] ^= gf_product(coef[(k + 4 - r) % 4], s[c * 4 + k]);
					end
				end
				s = t;
			end
			if (cmd == CMD_ENCRYPT) for (int n = 0; n < 16; n++) s[n] ^= sched[rnd * 16 + n];
		end
		for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = s[n];
		return res;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		$display("ERROR %0t: %s got %h, expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		block_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("ERROR %0t: result beat with nothing expected", $realtime);
			end else begin
				want = pending_results.pop_front();
				blocks_checked++;
				if (result_high !== want[127:64])
					report_mismatch("result_high", result_high, want[127:64]);
				if (result_low !== want[63:0])
					report_mismatch("result_low", result_low, want[63:0]);
			end
		end
	end

	// Output stall pattern, with one long hold-off on request.
	always @(posedge clk) begin
		if (hold_request && hold_count == 0) begin
			hold_count <= LongHold;
			out_stall <= 1'b1;
		end else if (hold_count > 1) begin
			hold_count <= hold_count - 1;
			out_stall <= 1'b1;
		end else begin
			if (hold_count == 1) hold_count <= 0;
			out_stall <= stalls_on ? ($urandom_range(0, 3) == 0) : 1'b0;
		end
	end

	// Watchdog on cycles without any beat.
	always @(posedge clk) begin
		if ((valid && !stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Timeout: no beat for %0d cycles", IdleLimit);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (KeySettle) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(bit index, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_key(block_t key);
		wait_drained();
		write_reg(REG_KEY_HIGH, key[127:64]);
		write_reg(REG_KEY_LOW, key[63:0]);
		cfg_valid <= 1'b0;
		cur_key = key;
		key_count++;
		// The decrypt key needs time to settle after a write.
		repeat (KeySettle) @(posedge clk);
	endtask

	task automatic send_block(cmd_t cmd, block_t blk, bit typed, block_t want);
		if (gaps_on && burst_left == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		valid <= 1'b1;
		command <= cmd;
		block_high <= blk[127:64];
		block_low <= blk[63:0];
		do @(posedge clk); while (!(valid && !stall));
		pending_results.push_back(typed ? want : aes_cipher(cmd, blk, cur_key));
		blocks_sent++;
		if (cmd == CMD_DECRYPT) decrypt_count++;
	endtask

	function automatic block_t random_block();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom, $urandom, $urandom};
		endcase
	endfunction

	localparam block_t FipsKey = 128'h000102030405060708090a0b0c0d0e0f;
	localparam block_t FipsPt  = 128'h00112233445566778899aabbccddeeff;
	localparam block_t FipsCt  = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
	localparam block_t ZeroCt  = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;

	vector_t known_answers[] = '{
		'{'0, CMD_ENCRYPT, '0, 1'b1, ZeroCt},
		'{'0, CMD_DECRYPT, ZeroCt, 1'b1, '0},
		'{'0, CMD_ENCRYPT, '1, 1'b0, '0},
		'{'0, CMD_DECRYPT, '1, 1'b0, '0},
		'{FipsKey, CMD_ENCRYPT, FipsPt, 1'b1, FipsCt},
		'{FipsKey, CMD_DECRYPT, FipsCt, 1'b1, FipsPt},
		'{FipsKey, CMD_ENCRYPT, '0, 1'b0, '0},
		'{FipsKey, CMD_DECRYPT, '0, 1'b0, '0},
		'{FipsKey, CMD_ENCRYPT, '1, 1'b0, '0},
		'{FipsKey, CMD_DECRYPT, '1, 1'b0, '0},
		'{FipsKey, CMD_ENCRYPT, 128'h8000_0000_0000_0000_0000_0000_0000_0001, 1'b0, '0},
		'{'1, CMD_ENCRYPT, '0, 1'b0, '0},
		'{'1, CMD_DECRYPT, '0, 1'b0, '0},
		'{'1, CMD_ENCRYPT, '1, 1'b0, '0},
		'{'1, CMD_DECRYPT, '1, 1'b0, '0},
		'{{64'hffff_ffff_ffff_ffff, 64'h0}, CMD_ENCRYPT, FipsPt, 1'b0, '0},
		'{{64'hffff_ffff_ffff_ffff, 64'h0}, CMD_DECRYPT, FipsPt, 1'b0, '0},
		'{{64'h0, 64'hffff_ffff_ffff_ffff}, CMD_ENCRYPT, FipsPt, 1'b0, '0},
		'{{64'h0, 64'hffff_ffff_ffff_ffff}, CMD_DECRYPT, FipsPt, 1'b0, '0}
	};

	initial begin
		block_t blk;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (KeySettle) @(posedge clk);

		// Known answers; the first rows run on the key left by reset.
		foreach (known_answers[i]) begin
			if (known_answers[i].key !== cur_key) begin
				valid <= 1'b0;
				load_key(known_answers[i].key);
			end
			send_block(known_answers[i].cmd, known_answers[i].blk,
				known_answers[i].typed, known_answers[i].result);
		end
		valid <= 1'b0;

		// Random phases, each under a fresh key, with varying gaps and stalls.
		for (int phase = 0; phase < 6; phase++) begin
			load_key(phase == 5 ? '1 : {$urandom, $urandom, $urandom, $urandom});
			gaps_on = (phase % 3) != 0;
			stalls_on = phase >= 2;
			for (int i = 0; i < 280; i++) begin
				if (phase == 3 && i == 40) hold_request = 1'b1;
				if (phase == 3 && i == 41) hold_request = 1'b0;
				blk = random_block();
				send_block(cmd_t'($urandom_range(0, 1)), blk, 1'b0, '0);
			end
			valid <= 1'b0;
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d blocks (%0d decrypts) under %0d keys; %0d results checked.",
			blocks_sent, decrypt_count, key_count, blocks_checked);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
